// File: sv/vie_pkg.sv
`default_nettype none

package vie_pkg;

  // Sizes of the machine.
  localparam int unsigned MEM_BYTES_DEF = 256;
  localparam int unsigned REG_COUNT     = 16;

  // Request opcodes.
  localparam logic [1:0] IN_LOAD    = 2'd0;
  localparam logic [1:0] IN_EXEC    = 2'd1;
  localparam logic [1:0] IN_RESTART = 2'd2;
  localparam logic [1:0] IN_NOP     = 2'd3;

  // Instruction opcodes (top nibble of the instruction word).
  localparam logic [3:0] OP_LOAD  = 4'h1;
  localparam logic [3:0] OP_LDI   = 4'h2;
  localparam logic [3:0] OP_STORE = 4'h3;
  localparam logic [3:0] OP_MOVE  = 4'h4;
  localparam logic [3:0] OP_ADD   = 4'h5;
  localparam logic [3:0] OP_FADD  = 4'h6;
  localparam logic [3:0] OP_JUMP  = 4'hB;
  localparam logic [3:0] OP_HALT  = 4'hC;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HI,
    S_LO,
    S_DEC,
    S_OPND,
    S_ALU,
    S_FP
  } state_e;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD_BYTE,
    DP_RESTART,
    DP_REPORT,
    DP_FETCH_HI,
    DP_FETCH_LO,
    DP_CAPTURE_LO,
    DP_DECODE,
    DP_OPND,
    DP_ALU,
    DP_FLOAT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   finish;
  } dp_cmd_t;

  typedef struct packed {
    logic       halted;
    logic [3:0] xop;
  } dp_status_t;

  typedef struct packed {
    logic [7:0] next_pc;
    logic       halted;
    logic       reg_written;
    logic [3:0] reg_index;
    logic [7:0] reg_value;
    logic       mem_written;
    logic [7:0] mem_address;
    logic [7:0] mem_value;
    logic [3:0] executed_op;
  } result_t;

endpackage

`default_nettype wire

// File: sv/vie_if.sv
`default_nettype none

// Request channel.
interface vie_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] load_address;
  logic [7:0] load_data;

  modport source (output valid, opcode, load_address, load_data, input ready);
  modport sink (input valid, opcode, load_address, load_data, output ready);
endinterface

// Result channel.
interface vie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] next_pc;
  logic       halted;
  logic       reg_written;
  logic [3:0] reg_index;
  logic [7:0] reg_value;
  logic       mem_written;
  logic [7:0] mem_address;
  logic [7:0] mem_value;
  logic [3:0] executed_op;

  modport source (output valid, next_pc, halted, reg_written, reg_index, reg_value,
                  mem_written, mem_address, mem_value, executed_op, input ready);
  modport sink (input valid, next_pc, halted, reg_written, reg_index, reg_value,
                mem_written, mem_address, mem_value, executed_op, output ready);
endinterface

`default_nettype wire

// File: sv/vie_datapath.sv
`default_nettype none

module vie_datapath #(
  parameter int unsigned MEM_BYTES = vie_pkg::MEM_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vie_pkg::dp_cmd_t    cmd_i,
  input  logic [7:0]          load_address_i,
  input  logic [7:0]          load_data_i,
  output vie_pkg::dp_status_t status_o,
  output vie_pkg::result_t    result_o
);
  import vie_pkg::*;

  localparam int unsigned AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;

  // Address reduction modulo the memory size by conditional subtraction.
  function automatic logic [AW-1:0] addr_of(input logic [7:0] a);
    logic [12:0] r;
    r = {5'b0, a};
    for (int k = 4; k >= 0; k--) begin
      if (r >= (13'(MEM_BYTES) << k)) r = r - (13'(MEM_BYTES) << k);
    end
    return r[AW-1:0];
  endfunction

  // Signed 4.8 fixed point value of a float byte.
  function automatic logic signed [12:0] fmag(input logic [7:0] v);
    logic [10:0] m;
    m = 11'(v[3:0]) << v[6:4];
    return v[7] ? -$signed({2'b0, m}) : $signed({2'b0, m});
  endfunction

  // Re-encode a signed 4.8 sum into the float byte format.
  function automatic logic [7:0] fenc(input logic signed [12:0] s);
    logic [11:0] mag;
    logic [3:0]  ip;
    logic [2:0]  len;
    logic [2:0]  expf;
    logic [11:0] sh;
    mag  = s[12] ? 12'(-s) : 12'(s);
    ip   = mag[11:8];
    len  = ip[3] ? 3'd4 : ip[2] ? 3'd3 : ip[1] ? 3'd2 : ip[0] ? 3'd1 : 3'd0;
    expf = 3'(len + 3'd4);
    sh   = (mag >> 4) >> len;
    return {s[12], expf, sh[3:0]};
  endfunction

  logic [7:0]          mem_q [MEM_BYTES];
  logic [MEM_BYTES-1:0] mem_vld_q;
  logic [7:0]          mem_rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata;

  logic [7:0] rf_q [REG_COUNT];
  logic [3:0] rf_raddr;
  logic [7:0] rf_rdata;

  logic [7:0] pc_q, pc_d;
  logic       halt_q, halt_d;
  logic [7:0] hi_q, hi_d, lo_q, lo_d, a_q, a_d;
  logic signed [12:0] fsum_q, fsum_d;

  logic       rw, mw, exec, jump, stop;
  logic [3:0] ri;
  logic [7:0] rv, ma, mv;
  logic [3:0] xop, r_f, x_f, y_f;
  result_t    res_q;

  assign xop = hi_q[7:4];
  assign r_f = hi_q[3:0];
  assign x_f = lo_q[7:4];
  assign y_f = lo_q[3:0];
  assign rf_rdata = rf_q[rf_raddr];

  // Main memory array with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem_vld_q[mem_raddr] ? mem_q[mem_raddr] : '0;
  end

  // Per-entry valid bits: an unwritten byte reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (mem_we) begin
      mem_vld_q[mem_waddr] <= 1'b1;
    end
  end

  // Operation decode.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = addr_of(load_address_i);
    mem_wdata = load_data_i;
    mem_raddr = addr_of(pc_q);
    rf_raddr  = r_f;
    hi_d      = hi_q;
    lo_d      = lo_q;
    a_d       = a_q;
    fsum_d    = fsum_q;
    rw = 1'b0; ri = '0; rv = '0;
    mw = 1'b0; ma = '0; mv = '0;
    exec = 1'b0; jump = 1'b0; stop = 1'b0;
    unique case (cmd_i.op)
      DP_LOAD_BYTE: mem_we = 1'b1;
      DP_FETCH_HI:  mem_re = 1'b1;
      DP_FETCH_LO: begin
        hi_d      = mem_rdata_q;
        mem_re    = 1'b1;
        mem_raddr = addr_of(pc_q + 8'd1);
      end
      DP_CAPTURE_LO: lo_d = mem_rdata_q;
      DP_DECODE: begin
        exec = 1'b1;
        unique case (xop)
          OP_LOAD: begin
            mem_re    = 1'b1;
            mem_raddr = addr_of(lo_q);
          end
          OP_LDI: begin
            rw = 1'b1; ri = r_f; rv = lo_q;
          end
          OP_STORE: begin
            rf_raddr  = r_f;
            mw        = 1'b1;
            ma        = 8'(addr_of(lo_q));
            mv        = rf_rdata;
            mem_we    = 1'b1;
            mem_waddr = addr_of(lo_q);
            mem_wdata = rf_rdata;
          end
          OP_MOVE: begin
            rf_raddr = x_f;
            rw = 1'b1; ri = y_f; rv = rf_rdata;
          end
          OP_ADD, OP_FADD: begin
            rf_raddr = x_f;
            a_d      = rf_rdata;
          end
          OP_JUMP: begin
            rf_raddr = r_f;
            jump     = (rf_rdata == rf_q[0]);
          end
          OP_HALT: stop = 1'b1;
          default: ;
        endcase
      end
      DP_OPND: begin
        exec = 1'b1;
        rw = 1'b1; ri = r_f; rv = mem_rdata_q;
      end
      DP_ALU: begin
        exec     = 1'b1;
        rf_raddr = y_f;
        if (xop == OP_ADD) begin
          rw = 1'b1; ri = r_f; rv = a_q + rf_rdata;
        end else begin
          fsum_d = fmag(a_q) + fmag(rf_rdata);
        end
      end
      DP_FLOAT: begin
        exec = 1'b1;
        rw = 1'b1; ri = r_f; rv = fenc(fsum_q);
      end
      default: ;
    endcase
  end

  // Program counter and halt flag update.
  always_comb begin
    pc_d   = pc_q;
    halt_d = halt_q;
    if (cmd_i.op == DP_RESTART) begin
      pc_d   = '0;
      halt_d = 1'b0;
    end else if (cmd_i.finish && exec) begin
      if (jump) begin
        pc_d = lo_q;
      end else if (stop) begin
        halt_d = 1'b1;
      end else begin
        pc_d = pc_q + 8'd2;
        if (pc_q >= 8'd254) halt_d = 1'b1;
      end
    end
  end

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q   <= '0;
      halt_q <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
    end else begin
      pc_q   <= pc_d;
      halt_q <= halt_d;
      if (cmd_i.finish && rw) rf_q[ri] <= rv;
    end
  end

  // Instruction and operand holding registers.
  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    a_q    <= a_d;
    fsum_q <= fsum_d;
  end

  // Result register, loaded when a request completes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_q.next_pc     <= pc_d;
      res_q.halted      <= halt_d;
      res_q.reg_written <= rw;
      res_q.reg_index   <= ri;
      res_q.reg_value   <= rv;
      res_q.mem_written <= mw;
      res_q.mem_address <= ma;
      res_q.mem_value   <= mv;
      res_q.executed_op <= exec ? xop : 4'h0;
    end
  end

  assign result_o        = res_q;
  assign status_o.halted = halt_q;
  assign status_o.xop    = xop;

endmodule

`default_nettype wire

// File: sv/vie_controller.sv
`default_nettype none

module vie_controller (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          in_opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  vie_pkg::dp_status_t status_i,
  output vie_pkg::dp_cmd_t    cmd_o
);
  import vie_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_opcode_i == IN_EXEC && !status_i.halted) state_d = S_HI;
      end
      S_HI: state_d = S_LO;
      S_LO: state_d = S_DEC;
      S_DEC: begin
        priority if (status_i.xop == OP_LOAD) state_d = S_OPND;
        else if (status_i.xop == OP_ADD || status_i.xop == OP_FADD) state_d = S_ALU;
        else state_d = S_IDLE;
      end
      S_OPND: state_d = S_IDLE;
      S_ALU:  state_d = (status_i.xop == OP_ADD) ? S_IDLE : S_FP;
      S_FP:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o.op     = DP_IDLE;
    cmd_o.finish = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode_i)
            IN_LOAD: begin
              cmd_o.op = DP_LOAD_BYTE; cmd_o.finish = 1'b1;
            end
            IN_EXEC: begin
              if (status_i.halted) begin
                cmd_o.op = DP_REPORT; cmd_o.finish = 1'b1;
              end else begin
                cmd_o.op = DP_FETCH_HI;
              end
            end
            IN_RESTART: begin
              cmd_o.op = DP_RESTART; cmd_o.finish = 1'b1;
            end
            IN_NOP: begin
              cmd_o.op = DP_REPORT; cmd_o.finish = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_HI: cmd_o.op = DP_FETCH_LO;
      S_LO: cmd_o.op = DP_CAPTURE_LO;
      S_DEC: begin
        cmd_o.op     = DP_DECODE;
        cmd_o.finish = !(status_i.xop == OP_LOAD || status_i.xop == OP_ADD ||
                         status_i.xop == OP_FADD);
      end
      S_OPND: begin
        cmd_o.op = DP_OPND; cmd_o.finish = 1'b1;
      end
      S_ALU: begin
        cmd_o.op = DP_ALU; cmd_o.finish = (status_i.xop == OP_ADD);
      end
      S_FP: begin
        cmd_o.op = DP_FLOAT; cmd_o.finish = 1'b1;
      end
      default: ;
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.finish) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  // A request only completes into a free result register.
  a_finish_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !out_valid_q) else $error("result overwritten");

  // A completed request is offered in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_q) else $error("result not offered");

  // Work starts only on an accepted request.
  a_leave_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d != S_IDLE) |-> accept) else $error("spurious start");

  // Decode is always preceded by the second fetch.
  a_fetch_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEC) |-> $past(state_q) == S_LO) else $error("decode out of order");

endmodule

`default_nettype wire

// File: sv/vole_instruction_executor.sv
// Timing: a load, restart or no-op request, and an execute request while halted, completes
// in its accept cycle; an execute request otherwise runs two instruction fetches and decode,
// plus an operand read for memory loads, an add for integer adds and an add and re-encode
// for float adds; the result appears the cycle after completion. One request at a time:
// the next request is taken the cycle after the result is.
// Reset (asynchronous, active low) clears registers, memory valid bits, counter and halt.
`default_nettype none

module vole_instruction_executor #(
  parameter int unsigned MEM_BYTES = vie_pkg::MEM_BYTES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  vie_in_if.sink    req_i,
  vie_out_if.source rsp_o
);
  import vie_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  result_t    result;

  vie_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_opcode_i (req_i.opcode),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  vie_datapath #(
    .MEM_BYTES (MEM_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .load_address_i (req_i.load_address),
    .load_data_i    (req_i.load_data),
    .status_o       (status),
    .result_o       (result)
  );

  assign rsp_o.next_pc     = result.next_pc;
  assign rsp_o.halted      = result.halted;
  assign rsp_o.reg_written = result.reg_written;
  assign rsp_o.reg_index   = result.reg_index;
  assign rsp_o.reg_value   = result.reg_value;
  assign rsp_o.mem_written = result.mem_written;
  assign rsp_o.mem_address = result.mem_address;
  assign rsp_o.mem_value   = result.mem_value;
  assign rsp_o.executed_op = result.executed_op;

endmodule

`default_nettype wire
